// ----- rtl/spba_pkg.sv -----
`default_nettype none

package spba_pkg;

    // Largest number of bins the index logic can address.
    localparam int MAX_BINS = 65536;
    localparam int BIN_W    = $clog2(MAX_BINS + 1);

    // Widths of the serial divider used for the weighted mean.
    localparam int DIVIDEND_W = 64;
    localparam int DIVISOR_W  = 32;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_THIN_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT     = 3'd4;

    typedef logic [BIN_W-1:0] t_bin;

endpackage

`default_nettype wire

// ----- rtl/spba_div.sv -----
`default_nettype none

module spba_div
    import spba_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire  [DIVIDEND_W-1:0] i_dividend,
    input  wire  [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_busy,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;

    logic [DIVISOR_W:0] w_shift;
    logic [DIVISOR_W:0] w_diff;
    logic               w_ge;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        w_shift = {r_rem, r_quo[DIVIDEND_W-1]};
        w_diff  = w_shift - {1'b0, i_divisor};
        w_ge    = (w_shift >= {1'b0, i_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(DIVIDEND_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[DIVISOR_W-1:0] : w_shift[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ----- rtl/sorted_point_bin_averager_core.sv -----
`default_nettype none
// Sequence: a pass-through transaction goes from idle through the pass state; a binned point
// runs the difference, bin multiply, compare, accumulate multiply and add states. Closing a bin
// adds the centre multiply, centre add, divide wait and emit states, with one quotient bit per
// cycle in the divider (none when the bin has no weight); pass and emit wait on the output.
// Throughput: one transaction at a time; the next is taken once the sequencer is idle again.
// Reset: synchronous, active low; configuration defaults, next point opens a new bin.

module sorted_point_bin_averager_core
    import spba_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // Configuration write port
    input  wire                  i_cfg_we,
    input  wire  [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire  [31:0]          i_cfg_data,
    // Input channel
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire  signed [31:0]   i_sample_x,
    input  wire  signed [31:0]   i_sample_y,
    input  wire  [15:0]          i_sample_weight,
    input  wire                  i_last_point,
    // Output channel
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic signed [31:0]   o_bin_center,
    output logic signed [31:0]   o_mean_y,
    output logic [31:0]          o_weight_sum,
    output logic                 o_zero_weight,
    output logic                 o_last_bin
);

    // Sequencer states. Each arithmetic step has a state of its own so that the
    // single multiplier and the divider are used in turn.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PASS   = 4'd1;   // pass-through result
    localparam logic [3:0] S_DIFF   = 4'd2;   // x - origin
    localparam logic [3:0] S_BINMUL = 4'd3;   // difference times inverse width
    localparam logic [3:0] S_BIN    = 4'd4;   // clamp index, compare with open bin
    localparam logic [3:0] S_ACCMUL = 4'd5;   // y times weight
    localparam logic [3:0] S_ACCADD = 4'd6;   // saturating accumulation
    localparam logic [3:0] S_CMUL   = 4'd7;   // centre product, divider start
    localparam logic [3:0] S_CADD   = 4'd8;   // centre add and saturation
    localparam logic [3:0] S_DIV    = 4'd9;   // wait for the mean
    localparam logic [3:0] S_EMIT   = 4'd10;  // hand the closed bin to the output

    // Configuration registers.
    logic               r_thin_enable;
    logic signed [31:0] r_origin_x;
    logic [30:0]        r_bin_width;
    logic [31:0]        r_inverse_width;
    logic [BIN_W-1:0]   r_bin_count;

    // Binning state.
    t_bin               r_open_bin;
    t_bin               r_bin;
    logic               r_stream_start;
    logic signed [63:0] r_wsum;
    logic [31:0]        r_wtot;
    logic               r_close_last;

    // Sequencer and working registers.
    logic [3:0]         r_state;
    logic [3:0]         n_state;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic [15:0]        r_w;
    logic               r_last;
    logic signed [32:0] r_diff;
    logic signed [66:0] r_prod;
    logic signed [31:0] r_centre;
    logic signed [31:0] r_mean;

    // Output register.
    logic               r_out_valid;
    logic signed [31:0] r_out_center;
    logic signed [31:0] r_out_mean;
    logic [31:0]        r_out_wsum;
    logic               r_out_zero;
    logic               r_out_last;

    logic                  w_accept;
    logic                  w_out_free;
    logic signed [33:0]    w_mul_a;
    logic signed [32:0]    w_mul_b;
    t_bin                  w_limit;
    t_bin                  w_new_bin;
    logic [BIN_W:0]        w_twice_bin;
    logic signed [64:0]    w_sum_ext;
    logic signed [63:0]    w_sum_sat;
    logic [32:0]           w_tot_ext;
    logic [31:0]           w_tot_sat;
    logic signed [49:0]    w_centre_ext;
    logic signed [31:0]    w_centre_sat;
    logic [DIVIDEND_W-1:0] w_mag;
    logic                  w_div_start;
    logic                  w_div_busy;
    logic [DIVIDEND_W-1:0] w_quo;
    logic [31:0]           w_mean_mag;
    logic signed [31:0]    w_mean;
    logic                  w_load_out;

    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = (r_state == S_IDLE);

    // Configuration writes. Writes to indexes beyond the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thin_enable   <= 1'b0;
            r_origin_x      <= '0;
            r_bin_width     <= 31'd65536;
            r_inverse_width <= 32'd65536;
            r_bin_count     <= BIN_W'(2);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THIN_ENABLE:   r_thin_enable   <= i_cfg_data[0];
                CFG_ORIGIN_X:      r_origin_x      <= i_cfg_data;
                CFG_BIN_WIDTH:     r_bin_width     <= i_cfg_data[30:0];
                CFG_INVERSE_WIDTH: r_inverse_width <= i_cfg_data;
                CFG_BIN_COUNT:     r_bin_count     <= i_cfg_data[BIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The upper bin limit: a bin count of zero behaves as one, and anything
    // above the supported maximum is held at that maximum.
    always_comb begin
        if (r_bin_count == '0) begin
            w_limit = BIN_W'(1);
        end else if (r_bin_count > BIN_W'(MAX_BINS)) begin
            w_limit = BIN_W'(MAX_BINS);
        end else begin
            w_limit = r_bin_count;
        end
    end

    // The shared multiplier. Its operands are chosen by the sequencer state and
    // the product is always registered before it is used.
    assign w_twice_bin = {r_open_bin, 1'b0} - 1'b1;

    always_comb begin
        unique case (r_state)
            S_BINMUL: begin
                w_mul_a = {r_diff[32], r_diff};
                w_mul_b = {1'b0, r_inverse_width};
            end
            S_ACCMUL: begin
                w_mul_a = {{2{r_y[31]}}, r_y};
                w_mul_b = {17'd0, r_w};
            end
            S_CMUL: begin
                w_mul_a = {{(34 - BIN_W - 1){1'b0}}, w_twice_bin};
                w_mul_b = {2'b00, r_bin_width};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 67'(w_mul_a * w_mul_b);
    end

    // Bin index: a negative offset lands in bin one; otherwise the integer part
    // of the Q32.32 product plus one, held at the limit. The limit comparison is
    // made before the increment: integer part + 1 > limit is integer part >= limit.
    always_comb begin
        if (r_diff[32]) begin
            w_new_bin = BIN_W'(1);
        end else if (r_prod[63:32] >= {{(32 - BIN_W){1'b0}}, w_limit}) begin
            w_new_bin = w_limit;
        end else begin
            w_new_bin = r_prod[32 + BIN_W - 1:32] + 1'b1;
        end
    end

    // Saturating accumulation of weight and weighted y. The y * weight product
    // is at most 48 bits wide, so the low 65 bits of the product carry it exactly.
    always_comb begin
        w_sum_ext = {r_wsum[63], r_wsum} + r_prod[64:0];
        if (w_sum_ext[64] != w_sum_ext[63]) begin
            w_sum_sat = w_sum_ext[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            w_sum_sat = w_sum_ext[63:0];
        end
        w_tot_ext = {1'b0, r_wtot} + {17'd0, r_w};
        w_tot_sat = w_tot_ext[32] ? 32'hFFFF_FFFF : w_tot_ext[31:0];
    end

    // Bin centre: origin plus half of (2 * bin - 1) * width, saturated to 32 bits.
    // The product is below 2^49, so bits 48 to 1 hold the halved value.
    always_comb begin
        w_centre_ext = {{18{r_origin_x[31]}}, r_origin_x} + {2'b00, r_prod[48:1]};
        if (w_centre_ext > 50'sd2147483647) begin
            w_centre_sat = 32'sh7FFF_FFFF;
        end else if (w_centre_ext < -50'sd2147483648) begin
            w_centre_sat = 32'sh8000_0000;
        end else begin
            w_centre_sat = w_centre_ext[31:0];
        end
    end

    // The mean is formed as an unsigned division of the magnitude; the sign is
    // put back afterwards and the result saturated, truncating toward zero.
    assign w_mag       = r_wsum[63] ? (~r_wsum + 1'b1) : r_wsum;
    assign w_div_start = (r_state == S_CMUL) && (r_wtot != '0);

    spba_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mag),
        .i_divisor  (r_wtot),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    always_comb begin
        if (r_wsum[63]) begin
            w_mean_mag = (w_quo > 64'h8000_0000) ? 32'h8000_0000 : w_quo[31:0];
            w_mean     = -w_mean_mag;
        end else begin
            w_mean_mag = (w_quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : w_quo[31:0];
            w_mean     = w_mean_mag;
        end
    end

    // A result is loaded into the output register only when it is empty or its
    // current transaction completes in the same cycle.
    assign w_load_out = ((r_state == S_PASS) || (r_state == S_EMIT)) && w_out_free;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = r_thin_enable ? S_DIFF : S_PASS;
                end
            end
            S_PASS: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DIFF:   n_state = S_BINMUL;
            S_BINMUL: n_state = S_BIN;
            S_BIN: begin
                if (!r_stream_start && (w_new_bin != r_open_bin)) begin
                    n_state = S_CMUL;
                end else begin
                    n_state = S_ACCMUL;
                end
            end
            S_ACCMUL: n_state = S_ACCADD;
            S_ACCADD: n_state = r_last ? S_CMUL : S_IDLE;
            S_CMUL:   n_state = S_CADD;
            S_CADD:   n_state = S_DIV;
            S_DIV: begin
                if ((r_wtot == '0) || !w_div_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = r_close_last ? S_IDLE : S_ACCMUL;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Point capture and intermediate results.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x    <= i_sample_x;
            r_y    <= i_sample_y;
            r_w    <= i_sample_weight;
            r_last <= i_last_point;
        end
        if (r_state == S_DIFF) begin
            r_diff <= {r_x[31], r_x} - {r_origin_x[31], r_origin_x};
        end
        if (r_state == S_BIN) begin
            r_bin <= w_new_bin;
        end
        if (r_state == S_CADD) begin
            r_centre <= w_centre_sat;
        end
        if (r_state == S_DIV) begin
            r_mean <= (r_wtot == '0) ? 32'sd0 : w_mean;
        end
    end

    // Bin state. A bin change closes the open bin first and only then opens the
    // new one; a last point closes its bin and re-arms the start of a data set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_bin     <= BIN_W'(1);
            r_stream_start <= 1'b1;
            r_wsum         <= '0;
            r_wtot         <= '0;
            r_close_last   <= 1'b0;
        end else begin
            unique case (r_state)
                S_BIN: begin
                    if (r_stream_start) begin
                        r_stream_start <= 1'b0;
                        r_open_bin     <= w_new_bin;
                        r_wsum         <= '0;
                        r_wtot         <= '0;
                    end else if (w_new_bin != r_open_bin) begin
                        r_close_last <= 1'b0;
                    end
                end
                S_ACCADD: begin
                    r_wsum <= w_sum_sat;
                    r_wtot <= w_tot_sat;
                    if (r_last) begin
                        r_close_last <= 1'b1;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_wsum <= '0;
                        r_wtot <= '0;
                        if (r_close_last) begin
                            r_open_bin     <= BIN_W'(1);
                            r_stream_start <= 1'b1;
                        end else begin
                            r_open_bin <= r_bin;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            if (r_state == S_PASS) begin
                r_out_center <= r_x;
                r_out_mean   <= r_y;
                r_out_wsum   <= {16'd0, r_w};
                r_out_zero   <= 1'b0;
                r_out_last   <= r_last;
            end else begin
                r_out_center <= r_centre;
                r_out_mean   <= r_mean;
                r_out_wsum   <= r_wtot;
                r_out_zero   <= (r_wtot == '0);
                r_out_last   <= r_close_last;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_bin_center  = r_out_center;
    assign o_mean_y      = r_out_mean;
    assign o_weight_sum  = r_out_wsum;
    assign o_zero_weight = r_out_zero;
    assign o_last_bin    = r_out_last;

`ifndef NO_ASSERTIONS
    // A closed bin is never handed on while its mean is still being divided.
    a_emit_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !w_div_busy)
        else $error("bin emitted while the divider is busy");

    // The open bin always lies within the supported range.
    a_open_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_open_bin >= BIN_W'(1)) && (r_open_bin <= BIN_W'(MAX_BINS)))
        else $error("open bin outside the supported range");

    // At the start of a data set nothing has been accumulated yet.
    a_start_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stream_start |-> ((r_wtot == '0) && (r_wsum == '0)))
        else $error("accumulators not cleared at the start of a data set");

    // With binning disabled an accepted transaction goes straight to pass-through.
    a_pass_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !r_thin_enable) |=> (r_state == S_PASS))
        else $error("pass-through transaction took the binning path");
`endif

endmodule

`default_nettype wire
